/* rtl/motor_drive_reversal_ramp_defines.svh */
// ---------------------------------------------------------------------------
// Motor drive reversal ramp: assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef MOTOR_DRIVE_REVERSAL_RAMP_DEFINES_SVH
`define MOTOR_DRIVE_REVERSAL_RAMP_DEFINES_SVH

// condition holds at every edge
`define MDRR_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define MDRR_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define MDRR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/mdrr_pkg.sv */
// ---------------------------------------------------------------------------
// Motor drive reversal ramp: package
// Field widths, register codes, driver kinds and channel payload types.
// ---------------------------------------------------------------------------
`default_nettype none

package mdrr_pkg;

    // field widths
    localparam int SPEED_W    = 11;
    localparam int TIME_W     = 32;
    localparam int RATE_W     = 16;
    localparam int PULSE_W    = 12;
    localparam int DUTY_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // ramp arithmetic: d * rate, scaled value, rounded value
    localparam int PROD_W = TIME_W + RATE_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int REACH_W = SUM_W - 7;

    // ESC neutral pulse in microseconds
    localparam logic [PULSE_W-1:0] ESC_IDLE_US = 12'd1500;

    // register reset values
    localparam logic [RATE_W-1:0]  RAMP_RATE_RST  = 16'd256;
    localparam logic [PULSE_W-1:0] STOP_PULSE_RST = 12'd500;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVER_KIND    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_RATE_UP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_RATE_DOWN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_PULSE     = 2'd3;

    typedef enum logic [1:0] {
        KIND_HBRIDGE     = 2'd0,
        KIND_HALF_BRIDGE = 2'd1,
        KIND_ESC         = 2'd2
    } t_driver_kind;

    // input item
    typedef struct packed {
        logic signed [SPEED_W-1:0] speed_request;
        logic [TIME_W-1:0]         now_ms;
    } t_cmd;

    // result item
    typedef struct packed {
        logic               spin_accepted;
        logic               dir_a_level;
        logic               dir_b_level;
        logic [DUTY_W-1:0]  bridge_duty;
        logic [DUTY_W-1:0]  half_a_duty;
        logic [DUTY_W-1:0]  half_b_duty;
        logic [PULSE_W-1:0] esc_pulse_us;
        logic               esc_written;
    } t_result;

    // configuration write
    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } t_cfg_wr;

    // ramp evaluator operands
    typedef struct packed {
        logic signed [SPEED_W-1:0] last_applied;
        logic signed [SPEED_W-1:0] ramp_target;
        logic signed [SPEED_W-1:0] request;
        logic [TIME_W-1:0]         start_time;
        logic [TIME_W-1:0]         now_ms;
        logic [RATE_W-1:0]         rate_up;
        logic [RATE_W-1:0]         rate_down;
    } t_ramp_in;

    // ramp evaluator status
    typedef struct packed {
        logic                      reaches;
        logic                      crosses;
        logic signed [SPEED_W-1:0] value;
    } t_ramp_eval;

endpackage

`default_nettype wire

/* rtl/mdrr_chan_if.sv */
// ---------------------------------------------------------------------------
// Motor drive reversal ramp: valid/ready channel
// One item moves at an edge where valid and ready are both high.
// ---------------------------------------------------------------------------
`default_nettype none

interface mdrr_chan_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/motor_drive_reversal_ramp.sv */
// Each item is held in the input register, then in the result register.
// Throughput: one item per cycle unless the result side stalls; the state loop
// runs through the 32x16 ramp multiply, the add and rounding, and the compare
// to the request. Reset (synchronous, active low): both stages empty,
// registers at their reset values, ramp disarmed, ESC pulse 1500 us.
// ---------------------------------------------------------------------------
// Motor drive reversal ramp: top level
// Maps speed commands to H-bridge, dual half-bridge or ESC outputs, holding
// ESC reversals and stops back until the slew ramp allows them.
// ---------------------------------------------------------------------------
`default_nettype none

`include "motor_drive_reversal_ramp_defines.svh"

module motor_drive_reversal_ramp #(
    parameter int SPEED_MAX = 1023
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mdrr_chan_if.sink   i_cmd,
    mdrr_chan_if.source o_res,
    mdrr_chan_if.sink   i_cfg
);

    localparam int SW = mdrr_pkg::SPEED_W;
    localparam int DW = mdrr_pkg::DUTY_W;
    localparam int PUW = mdrr_pkg::PULSE_W;
    localparam logic signed [SW-1:0] SPEED_HI = SW'(SPEED_MAX);

    // configuration registers
    mdrr_pkg::t_driver_kind           r_driver_kind;
    logic [mdrr_pkg::RATE_W-1:0]      r_rate_up;
    logic [mdrr_pkg::RATE_W-1:0]      r_rate_down;
    logic [PUW-1:0]                   r_stop_pulse;

    // pipeline registers
    logic                  r_cmd_valid;
    mdrr_pkg::t_cmd        r_cmd;
    logic                  r_res_valid;
    mdrr_pkg::t_result     r_res;

    // block state
    logic signed [SW-1:0]         r_last_applied, n_last_applied;
    logic signed [SW-1:0]         r_ramp_target, n_ramp_target;
    logic [mdrr_pkg::TIME_W-1:0]  r_ramp_start, n_ramp_start;
    logic                         r_ramp_armed, n_ramp_armed;
    logic                         r_dir_a, n_dir_a;
    logic                         r_dir_b, n_dir_b;
    logic [PUW-1:0]               r_esc_pulse, n_esc_pulse;

    logic                  w_adv;
    logic signed [SW-1:0]  w_req;
    logic [SW-1:0]         w_req_mag;
    mdrr_pkg::t_ramp_in    w_ramp_in;
    mdrr_pkg::t_ramp_eval  w_eval;
    mdrr_pkg::t_result     w_res;

    // handshakes
    assign w_adv       = r_cmd_valid && (!r_res_valid || o_res.ready);
    assign i_cmd.ready = !r_cmd_valid || w_adv;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_res_valid;
    assign o_res.data  = r_res;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_driver_kind <= mdrr_pkg::KIND_HBRIDGE;
            r_rate_up     <= mdrr_pkg::RAMP_RATE_RST;
            r_rate_down   <= mdrr_pkg::RAMP_RATE_RST;
            r_stop_pulse  <= mdrr_pkg::STOP_PULSE_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                mdrr_pkg::CFG_DRIVER_KIND:
                    r_driver_kind <= mdrr_pkg::t_driver_kind'(i_cfg.data.value[1:0]);
                mdrr_pkg::CFG_RAMP_RATE_UP:   r_rate_up   <= i_cfg.data.value;
                mdrr_pkg::CFG_RAMP_RATE_DOWN: r_rate_down <= i_cfg.data.value;
                mdrr_pkg::CFG_STOP_PULSE:     r_stop_pulse <= i_cfg.data.value[PUW-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_cmd_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_cmd <= i_cmd.data;
        end
    end

    // request clamped to the speed range
    always_comb begin
        if (r_cmd.speed_request > SPEED_HI) begin
            w_req = SPEED_HI;
        end else if (r_cmd.speed_request < -SPEED_HI) begin
            w_req = -SPEED_HI;
        end else begin
            w_req = r_cmd.speed_request;
        end
    end
    assign w_req_mag = w_req[SW-1] ? SW'(-w_req) : SW'(w_req);

    // ramp evaluation against the current state
    assign w_ramp_in.last_applied = r_last_applied;
    assign w_ramp_in.ramp_target  = r_ramp_target;
    assign w_ramp_in.request      = w_req;
    assign w_ramp_in.start_time   = r_ramp_start;
    assign w_ramp_in.now_ms       = r_cmd.now_ms;
    assign w_ramp_in.rate_up      = r_rate_up;
    assign w_ramp_in.rate_down    = r_rate_down;

    mdrr_ramp #(
        .SPEED_MAX (SPEED_MAX)
    ) u_ramp (
        .i_ramp (w_ramp_in),
        .o_eval (w_eval)
    );

    // one command: next state and result
    always_comb begin
        n_last_applied = r_last_applied;
        n_ramp_target  = r_ramp_target;
        n_ramp_start   = r_ramp_start;
        n_ramp_armed   = r_ramp_armed;
        n_dir_a        = r_dir_a;
        n_dir_b        = r_dir_b;
        n_esc_pulse    = r_esc_pulse;
        w_res          = '0;
        w_res.spin_accepted = 1'b1;

        case (r_driver_kind)
            mdrr_pkg::KIND_HBRIDGE: begin
                if (w_req > 0) begin
                    n_dir_a = 1'b1;
                    n_dir_b = 1'b0;
                end else if (w_req < 0) begin
                    n_dir_a = 1'b0;
                    n_dir_b = 1'b1;
                end
                w_res.bridge_duty = w_req_mag[DW-1:0];
                n_last_applied = w_req;
                n_ramp_target  = '0;
                n_ramp_start   = '0;
                n_ramp_armed   = 1'b0;
            end
            mdrr_pkg::KIND_HALF_BRIDGE: begin
                if (w_req > 0) begin
                    w_res.half_b_duty = w_req_mag[DW-1:0];
                end else if (w_req < 0) begin
                    w_res.half_a_duty = w_req_mag[DW-1:0];
                end
                n_last_applied = w_req;
                n_ramp_target  = '0;
                n_ramp_start   = '0;
                n_ramp_armed   = 1'b0;
            end
            mdrr_pkg::KIND_ESC: begin
                if (w_req == 0 && r_last_applied != 0) begin
                    // stop while moving: stop pulse, wait for the ramp
                    n_esc_pulse = r_stop_pulse;
                    w_res.esc_written   = 1'b1;
                    w_res.spin_accepted = 1'b0;
                    if (!r_ramp_armed) begin
                        n_ramp_target = '0;
                        n_ramp_start  = r_cmd.now_ms;
                        n_ramp_armed  = 1'b1;
                    end else if (w_eval.crosses) begin
                        w_res.spin_accepted = 1'b1;
                        n_last_applied = '0;
                        n_ramp_target  = '0;
                        n_ramp_start   = '0;
                        n_ramp_armed   = 1'b0;
                    end
                end else if (w_req == 0) begin
                    // stop while stopped
                    n_esc_pulse = r_stop_pulse;
                    w_res.esc_written = 1'b1;
                    n_last_applied = '0;
                    n_ramp_target  = '0;
                    n_ramp_start   = '0;
                    n_ramp_armed   = 1'b0;
                end else if ((w_req > 0 && r_last_applied >= 0)
                          || (w_req < 0 && r_last_applied <= 0)) begin
                    // same sign or start from rest
                    n_esc_pulse = mdrr_pkg::ESC_IDLE_US + PUW'(w_req);
                    w_res.esc_written = 1'b1;
                    n_last_applied = w_req;
                    n_ramp_target  = '0;
                    n_ramp_start   = '0;
                    n_ramp_armed   = 1'b0;
                end else if (!r_ramp_armed || r_ramp_target == 0) begin
                    // reversal: idle pulse and arm toward the request
                    n_esc_pulse = mdrr_pkg::ESC_IDLE_US;
                    w_res.esc_written   = 1'b1;
                    w_res.spin_accepted = 1'b0;
                    n_ramp_target = w_req;
                    n_ramp_start  = r_cmd.now_ms;
                    n_ramp_armed  = 1'b1;
                end else if (w_eval.reaches) begin
                    n_esc_pulse = mdrr_pkg::ESC_IDLE_US + PUW'(w_req);
                    w_res.esc_written = 1'b1;
                    n_last_applied = w_req;
                    n_ramp_target  = '0;
                    n_ramp_start   = '0;
                    n_ramp_armed   = 1'b0;
                end else if (w_eval.crosses) begin
                    // past zero: apply what the ramp allows so far
                    n_esc_pulse = mdrr_pkg::ESC_IDLE_US + PUW'(w_eval.value);
                    w_res.esc_written = 1'b1;
                    n_last_applied = w_eval.value;
                    n_ramp_target  = '0;
                    n_ramp_start   = '0;
                    n_ramp_armed   = 1'b0;
                end else begin
                    w_res.spin_accepted = 1'b0;
                end
            end
            default: ;
        endcase

        w_res.dir_a_level  = n_dir_a;
        w_res.dir_b_level  = n_dir_b;
        w_res.esc_pulse_us = n_esc_pulse;
    end

    // state update per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_applied <= '0;
            r_ramp_target  <= '0;
            r_ramp_start   <= '0;
            r_ramp_armed   <= 1'b0;
            r_dir_a        <= 1'b0;
            r_dir_b        <= 1'b0;
            r_esc_pulse    <= mdrr_pkg::ESC_IDLE_US;
        end else if (w_adv) begin
            r_last_applied <= n_last_applied;
            r_ramp_target  <= n_ramp_target;
            r_ramp_start   <= n_ramp_start;
            r_ramp_armed   <= n_ramp_armed;
            r_dir_a        <= n_dir_a;
            r_dir_b        <= n_dir_b;
            r_esc_pulse    <= n_esc_pulse;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_adv) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    // checks
    `MDRR_ASSERT_IMPLIES(a_armed_moving, r_ramp_armed, r_last_applied != 0,
        "ramp armed while last applied speed is zero")
    `MDRR_ASSERT_IMPLIES(a_target_opposes, r_ramp_armed && r_ramp_target != 0,
        r_ramp_target[SW-1] != r_last_applied[SW-1],
        "armed ramp target has the sign of the last applied speed")
    `MDRR_ASSERT_NEXT(a_refusal_arms, w_adv && !w_res.spin_accepted, r_ramp_armed,
        "refused item left the ramp disarmed")
    `MDRR_ASSERT_HOLDS(a_dir_exclusive, !(r_dir_a && r_dir_b),
        "both direction levels high")
    `MDRR_ASSERT_IMPLIES(a_half_exclusive, r_res_valid,
        r_res.half_a_duty == 0 || r_res.half_b_duty == 0,
        "both half-bridge duties nonzero")

endmodule

`default_nettype wire

/* rtl/mdrr_ramp.sv */
// ---------------------------------------------------------------------------
// Motor drive reversal ramp: ramp evaluator
// Value reachable since the ramp start, rounded half away from zero, and
// its relation to the request and to zero.
// ---------------------------------------------------------------------------
`default_nettype none

module mdrr_ramp #(
    parameter int SPEED_MAX = 1023
) (
    input  var mdrr_pkg::t_ramp_in   i_ramp,
    output var mdrr_pkg::t_ramp_eval o_eval
);

    localparam int SW = mdrr_pkg::SPEED_W;
    localparam int PW = mdrr_pkg::PROD_W;
    localparam int UW = mdrr_pkg::SUM_W;
    localparam int RW = mdrr_pkg::REACH_W;

    localparam logic signed [RW-1:0] REACH_HI = RW'(SPEED_MAX);
    localparam logic signed [RW-1:0] REACH_LO = -REACH_HI;
    localparam logic signed [SW-1:0] SPEED_HI = SW'(SPEED_MAX);

    logic                      w_up;
    logic [mdrr_pkg::TIME_W-1:0] w_elapsed;
    logic [mdrr_pkg::RATE_W-1:0] w_rate;
    logic [PW-1:0]             w_prod;
    logic signed [UW-1:0]      w_base;
    logic signed [UW-1:0]      w_sum;
    logic [UW-1:0]             w_mag;
    logic [UW-1:0]             w_mag_rnd;
    logic signed [RW-1:0]      w_reach;
    logic signed [RW-1:0]      w_req_ext;
    logic signed [SW-1:0]      w_clamped;

    // direction of the ramp and elapsed time, mod 2^32
    assign w_up      = i_ramp.ramp_target > i_ramp.last_applied;
    assign w_elapsed = i_ramp.now_ms - i_ramp.start_time;
    assign w_rate    = w_up ? i_ramp.rate_up : i_ramp.rate_down;

    // 32x16 product in Q40.8 (rate in Q8.8), added to or subtracted from the scaled last value
    assign w_prod = PW'(w_elapsed) * PW'(w_rate);
    assign w_base = {{(UW-SW-8){i_ramp.last_applied[SW-1]}}, i_ramp.last_applied, 8'd0};
    assign w_sum  = w_up ? (w_base + signed'({2'b00, w_prod}))
                         : (w_base - signed'({2'b00, w_prod}));

    // round half away from zero
    assign w_mag     = w_sum[UW-1] ? UW'(-w_sum) : UW'(w_sum);
    assign w_mag_rnd = w_mag + UW'(128);
    assign w_reach   = w_sum[UW-1] ? -signed'({1'b0, w_mag_rnd[UW-1:8]})
                                   : signed'({1'b0, w_mag_rnd[UW-1:8]});

    assign w_req_ext = RW'(i_ramp.request);

    // clamp to the speed range
    always_comb begin
        if (w_reach > REACH_HI) begin
            w_clamped = SPEED_HI;
        end else if (w_reach < REACH_LO) begin
            w_clamped = -SPEED_HI;
        end else begin
            w_clamped = w_reach[SW-1:0];
        end
    end

    assign o_eval.reaches = w_up ? (w_reach >= w_req_ext) : (w_reach <= w_req_ext);
    assign o_eval.crosses = ((w_reach > 0) && (i_ramp.last_applied < 0))
                         || ((w_reach < 0) && (i_ramp.last_applied > 0));
    assign o_eval.value   = w_clamped;

endmodule

`default_nettype wire

/* sim/motor_drive_reversal_ramp_test.sv */
// ---------------------------------------------------------------------------
// Motor drive reversal ramp: testbench
// Drives speed commands through all three bridge kinds and checks every
// result field against a cycle-free model of the drive, including the ESC
// stop and reversal ramp, the clamp, held direction levels and time wrap.
// ---------------------------------------------------------------------------
`default_nettype none

module motor_drive_reversal_ramp_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SPEED_LIMIT   = 1023;
    localparam int QUIET_LIMIT   = 2000;
    localparam int STARVE_CYCLES = 90;
    localparam int IDLE_PCT      = 35;
    localparam int SETTLE_CYCLES = 4;

    logic i_clk;
    logic i_rst_n;

    mdrr_chan_if #(.t_data(mdrr_pkg::t_cmd))    cmd_ch ();
    mdrr_chan_if #(.t_data(mdrr_pkg::t_result)) res_ch ();
    mdrr_chan_if #(.t_data(mdrr_pkg::t_cfg_wr)) cfg_ch ();

    motor_drive_reversal_ramp #(
        .SPEED_MAX(SPEED_LIMIT)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch.sink),
        .o_res  (res_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    // stimulus and scoreboard storage
    mdrr_pkg::t_cmd    pending_cmds[$];
    mdrr_pkg::t_result expected_drive[$];
    int      mismatches = 0;
    int      quiet_cycles = 0;
    bit      cmd_fired = 0;
    bit      calm_mode = 0;
    bit      starve_rx = 0;
    int      rx_hold = 0;
    logic [mdrr_pkg::TIME_W-1:0] walk_ms;
    int      walk_speed = 0;

    // model copy of the registers
    mdrr_pkg::t_driver_kind       kind_cfg;
    logic [mdrr_pkg::RATE_W-1:0]  rate_up_cfg;
    logic [mdrr_pkg::RATE_W-1:0]  rate_down_cfg;
    logic [mdrr_pkg::PULSE_W-1:0] stop_pulse_cfg;

    // model copy of the drive state
    logic signed [mdrr_pkg::SPEED_W-1:0] applied_speed;
    logic signed [mdrr_pkg::SPEED_W-1:0] ramp_goal;
    logic [mdrr_pkg::TIME_W-1:0]         ramp_t0;
    bit                                  ramp_live;
    bit                                  dir_a_hold;
    bit                                  dir_b_hold;
    logic [mdrr_pkg::PULSE_W-1:0]        esc_hold;
    bit                                  esc_wrote;

    always #2 i_clk = ~i_clk;

    function automatic int clamp_speed(longint v);
        if (v > SPEED_LIMIT) return SPEED_LIMIT;
        if (v < -SPEED_LIMIT) return -SPEED_LIMIT;
        return int'(v);
    endfunction

    function automatic void drop_ramp();
        ramp_goal = '0;
        ramp_t0   = '0;
        ramp_live = 0;
    endfunction

    // value the ramp allows by now, Q8.8 rounded half away from zero
    function automatic longint ramp_reach(logic [mdrr_pkg::TIME_W-1:0] now,
                                          output bit upward);
        logic [mdrr_pkg::TIME_W-1:0] elapsed;
        logic [mdrr_pkg::RATE_W-1:0] rate;
        longint                      scaled;
        longint                      span;
        elapsed = now - ramp_t0;
        upward  = int'(ramp_goal) > int'(applied_speed);
        rate    = upward ? rate_up_cfg : rate_down_cfg;
        scaled  = longint'(applied_speed) * 256;
        span    = longint'({32'd0, elapsed}) * longint'({48'd0, rate});
        scaled  = upward ? scaled + span : scaled - span;
        if (scaled >= 0) return (scaled + 128) / 256;
        return -((-scaled + 128) / 256);
    endfunction

    function automatic bit past_zero(longint v);
        return (v > 0 && applied_speed < 0) || (v < 0 && applied_speed > 0);
    endfunction

    function automatic void esc_set(int us);
        esc_hold  = us[mdrr_pkg::PULSE_W-1:0];
        esc_wrote = 1;
    endfunction

    function automatic void esc_take(int v);
        esc_set(int'(mdrr_pkg::ESC_IDLE_US) + v);
        applied_speed = v[mdrr_pkg::SPEED_W-1:0];
        drop_ramp();
    endfunction

    // expected outputs for one command; advances the model state
    function automatic mdrr_pkg::t_result predict_drive(mdrr_pkg::t_cmd c);
        mdrr_pkg::t_result           r;
        int                          req;
        int                          mag;
        logic [mdrr_pkg::DUTY_W-1:0] duty;
        longint                      reach;
        bit                          up;
        bit                          acc;
        req       = clamp_speed(longint'(c.speed_request));
        mag       = (req < 0) ? -req : req;
        duty      = mag[mdrr_pkg::DUTY_W-1:0];
        r         = '0;
        acc       = 1;
        esc_wrote = 0;
        case (kind_cfg)
            mdrr_pkg::KIND_HBRIDGE: begin
                if (req > 0) begin
                    dir_a_hold = 1;
                    dir_b_hold = 0;
                end else if (req < 0) begin
                    dir_a_hold = 0;
                    dir_b_hold = 1;
                end
                r.bridge_duty = duty;
                applied_speed = req[mdrr_pkg::SPEED_W-1:0];
                drop_ramp();
            end
            mdrr_pkg::KIND_HALF_BRIDGE: begin
                if (req > 0) r.half_b_duty = duty;
                else if (req < 0) r.half_a_duty = duty;
                applied_speed = req[mdrr_pkg::SPEED_W-1:0];
                drop_ramp();
            end
            mdrr_pkg::KIND_ESC: begin
                if (req == 0 && applied_speed != 0) begin
                    // stop while moving: hold back until the ramp passes zero
                    esc_set(int'(stop_pulse_cfg));
                    acc = 0;
                    if (!ramp_live) begin
                        ramp_goal = '0;
                        ramp_t0   = c.now_ms;
                        ramp_live = 1;
                    end else begin
                        reach = ramp_reach(c.now_ms, up);
                        if (past_zero(reach)) begin
                            acc = 1;
                            applied_speed = '0;
                            drop_ramp();
                        end
                    end
                end else if (req == 0) begin
                    esc_set(int'(stop_pulse_cfg));
                    applied_speed = '0;
                    drop_ramp();
                end else if ((req > 0 && applied_speed >= 0) ||
                             (req < 0 && applied_speed <= 0)) begin
                    esc_take(req);
                end else if (!ramp_live || ramp_goal == 0) begin
                    // reversal: idle pulse and start a ramp toward the request
                    esc_set(int'(mdrr_pkg::ESC_IDLE_US));
                    acc       = 0;
                    ramp_goal = req[mdrr_pkg::SPEED_W-1:0];
                    ramp_t0   = c.now_ms;
                    ramp_live = 1;
                end else begin
                    reach = ramp_reach(c.now_ms, up);
                    if (up ? (reach >= req) : (reach <= req)) esc_take(req);
                    else if (past_zero(reach)) esc_take(clamp_speed(reach));
                    else acc = 0;
                end
            end
            default: ;
        endcase
        r.spin_accepted = acc;
        r.dir_a_level   = dir_a_hold;
        r.dir_b_level   = dir_b_hold;
        r.esc_pulse_us  = esc_hold;
        r.esc_written   = esc_wrote;
        return r;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // command sender: a new item only once the previous one has gone
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else if (!cmd_ch.valid || cmd_fired) begin
            if (pending_cmds.size() != 0 &&
                (calm_mode || $urandom_range(99) >= IDLE_PCT)) begin
                cmd_ch.valid <= 1'b1;
                cmd_ch.data  <= pending_cmds.pop_front();
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (starve_rx) begin
            rx_hold   = STARVE_CYCLES;
            starve_rx = 0;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= calm_mode || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // monitor: register copy, prediction, result check, watchdog
    always @(posedge i_clk) begin
        mdrr_pkg::t_result want;
        mdrr_pkg::t_result got;
        bit                res_fired;
        bit                cfg_fired;
        cmd_fired = i_rst_n && cmd_ch.valid && cmd_ch.ready;
        res_fired = i_rst_n && res_ch.valid && res_ch.ready;
        cfg_fired = i_rst_n && cfg_ch.valid && cfg_ch.ready;
        if (cfg_fired) begin
            case (cfg_ch.data.index)
                mdrr_pkg::CFG_DRIVER_KIND:
                    kind_cfg = mdrr_pkg::t_driver_kind'(cfg_ch.data.value[1:0]);
                mdrr_pkg::CFG_RAMP_RATE_UP:   rate_up_cfg = cfg_ch.data.value;
                mdrr_pkg::CFG_RAMP_RATE_DOWN: rate_down_cfg = cfg_ch.data.value;
                mdrr_pkg::CFG_STOP_PULSE:
                    stop_pulse_cfg = cfg_ch.data.value[mdrr_pkg::PULSE_W-1:0];
                default: ;
            endcase
        end
        if (cmd_fired) expected_drive.push_back(predict_drive(cmd_ch.data));
        if (res_fired) begin
            got = res_ch.data;
            if (expected_drive.size() == 0) begin
                $error("result arrived with nothing expected");
                mismatches++;
            end else begin
                want = expected_drive.pop_front();
                check_field("spin_accepted", want.spin_accepted, got.spin_accepted);
                check_field("dir_a_level", want.dir_a_level, got.dir_a_level);
                check_field("dir_b_level", want.dir_b_level, got.dir_b_level);
                check_field("bridge_duty", want.bridge_duty, got.bridge_duty);
                check_field("half_a_duty", want.half_a_duty, got.half_a_duty);
                check_field("half_b_duty", want.half_b_duty, got.half_b_duty);
                check_field("esc_pulse_us", want.esc_pulse_us, got.esc_pulse_us);
                check_field("esc_written", want.esc_written, got.esc_written);
            end
        end
        if (!i_rst_n || cmd_fired || res_fired || cfg_fired) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic queue_cmd(int spd, logic [mdrr_pkg::TIME_W-1:0] at);
        mdrr_pkg::t_cmd c;
        c.speed_request = spd[mdrr_pkg::SPEED_W-1:0];
        c.now_ms        = at;
        pending_cmds.push_back(c);
    endtask

    // register write; only called with nothing in flight
    task automatic write_reg(logic [mdrr_pkg::CFG_IDX_W-1:0] idx,
                             logic [mdrr_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{index: idx, value: val};
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // hold the sender until every expected result is back
    task automatic settle();
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || cmd_ch.valid || expected_drive.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // any speed, any time stamp
    task automatic queue_wide(int count);
        for (int n = 0; n < count; n++) begin
            queue_cmd(int'($urandom_range(2047)) - 1024, $urandom());
        end
    endtask

    // ESC traffic: rising time, retries, stops, reversals, extremes
    task automatic queue_esc_walk(int count);
        int pick;
        int spd;
        int mag;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(9);
            if (pick <= 5) walk_ms += $urandom_range(40);
            else if (pick <= 8) walk_ms += $urandom_range(1500, 41);
            else walk_ms = $urandom();
            pick = $urandom_range(99);
            mag  = $urandom_range(SPEED_LIMIT, 1);
            if (pick < 35) begin
                spd = walk_speed;
            end else if (pick < 50) begin
                spd = 0;
            end else if (pick < 58) begin
                case ($urandom_range(2))
                    0: spd = SPEED_LIMIT;
                    1: spd = -SPEED_LIMIT;
                    default: spd = -1024;
                endcase
            end else if (pick < 80) begin
                // reversal
                if (walk_speed > 0) spd = -mag;
                else if (walk_speed < 0) spd = mag;
                else spd = $urandom_range(1) ? mag : -mag;
            end else begin
                if (walk_speed > 0) spd = mag;
                else if (walk_speed < 0) spd = -mag;
                else spd = $urandom_range(1) ? mag : -mag;
            end
            walk_speed = spd;
            queue_cmd(spd, walk_ms);
        end
    endtask

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;

        kind_cfg       = mdrr_pkg::KIND_HBRIDGE;
        rate_up_cfg    = mdrr_pkg::RAMP_RATE_RST;
        rate_down_cfg  = mdrr_pkg::RAMP_RATE_RST;
        stop_pulse_cfg = mdrr_pkg::STOP_PULSE_RST;
        applied_speed  = '0;
        drop_ramp();
        dir_a_hold     = 0;
        dir_b_hold     = 0;
        esc_hold       = mdrr_pkg::ESC_IDLE_US;
        walk_ms        = $urandom();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // H-bridge at reset settings: extremes, clamp, held direction on zero
        queue_cmd(SPEED_LIMIT, 32'd0);
        queue_cmd(0, 32'd1);
        queue_cmd(-1024, 32'hFFFF_FFFF);
        queue_cmd(0, 32'd2);
        queue_cmd(1, 32'd3);
        settle();

        // dual half-bridge
        write_reg(mdrr_pkg::CFG_DRIVER_KIND, 16'(mdrr_pkg::KIND_HALF_BRIDGE));
        queue_cmd(-1024, 32'd10);
        queue_cmd(SPEED_LIMIT, 32'd11);
        queue_cmd(-1, 32'd12);
        queue_cmd(0, 32'd13);
        settle();

        // ESC at 1 unit per ms: stops, reversals, partial ramps, time wrap
        write_reg(mdrr_pkg::CFG_DRIVER_KIND, 16'(mdrr_pkg::KIND_ESC));
        queue_cmd(0, 32'd100);                 // stop while stopped
        queue_cmd(300, 32'd100);               // start from zero
        queue_cmd(500, 32'd110);               // same sign
        queue_cmd(0, 32'd200);                 // stop while moving arms
        queue_cmd(0, 32'd201);                 // not yet at zero
        queue_cmd(0, 32'd800);                 // ramp passes zero
        queue_cmd(400, 32'd810);
        queue_cmd(0, 32'd820);                 // arm toward zero
        queue_cmd(-200, 32'd821);              // reversal over a stop ramp
        queue_cmd(-200, 32'd822);              // too early, nothing changes
        queue_cmd(-200, 32'd1600);             // reaches the request
        queue_cmd(200, 32'd1610);
        queue_cmd(200, 32'd1750);              // still short of zero
        queue_cmd(200, 32'd1850);              // crosses, ramp value applied
        queue_cmd(-1024, 32'd1860);
        queue_cmd(-1024, 32'd5000);
        queue_cmd(SPEED_LIMIT, 32'hFFFF_FF00);
        queue_cmd(SPEED_LIMIT, 32'h0000_0400); // elapsed time across the wrap
        settle();

        write_reg(mdrr_pkg::CFG_DRIVER_KIND, 16'(mdrr_pkg::KIND_HBRIDGE));
        queue_wide(100);
        settle();

        write_reg(mdrr_pkg::CFG_DRIVER_KIND, 16'(mdrr_pkg::KIND_HALF_BRIDGE));
        queue_wide(100);
        settle();

        // ESC with a long receiver hold-off so the block backs up
        write_reg(mdrr_pkg::CFG_DRIVER_KIND, 16'(mdrr_pkg::KIND_ESC));
        write_reg(mdrr_pkg::CFG_RAMP_RATE_UP, 16'd256);
        write_reg(mdrr_pkg::CFG_RAMP_RATE_DOWN, 16'd256);
        write_reg(mdrr_pkg::CFG_STOP_PULSE, 16'd500);
        queue_esc_walk(150);
        starve_rx = 1;
        settle();

        // rate extremes, no idling on either side
        write_reg(mdrr_pkg::CFG_RAMP_RATE_UP, 16'd0);
        write_reg(mdrr_pkg::CFG_RAMP_RATE_DOWN, 16'hFFFF);
        write_reg(mdrr_pkg::CFG_STOP_PULSE, 16'd4095);
        calm_mode = 1;
        queue_esc_walk(100);
        settle();
        calm_mode = 0;

        write_reg(mdrr_pkg::CFG_RAMP_RATE_UP, 16'hFFFF);
        write_reg(mdrr_pkg::CFG_RAMP_RATE_DOWN, 16'd0);
        write_reg(mdrr_pkg::CFG_STOP_PULSE, 16'd0);
        queue_esc_walk(100);
        settle();

        // fractional rates exercise the rounding
        repeat (2) begin
            write_reg(mdrr_pkg::CFG_RAMP_RATE_UP, 16'($urandom_range(2048, 16)));
            write_reg(mdrr_pkg::CFG_RAMP_RATE_DOWN, 16'($urandom_range(2048, 16)));
            write_reg(mdrr_pkg::CFG_STOP_PULSE, 16'($urandom_range(4095)));
            queue_esc_walk(150);
            settle();
        end

        repeat (10) @(posedge i_clk);
        if (expected_drive.size() != 0) begin
            $error("%0d results never arrived", expected_drive.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl
rtl/mdrr_pkg.sv
rtl/mdrr_chan_if.sv
rtl/mdrr_ramp.sv
rtl/motor_drive_reversal_ramp.sv
sim/motor_drive_reversal_ramp_test.sv
